// ===== rtl/fsgs_pkg.sv =====
// ============================================================================
// fsgs_pkg - shared types and constants for the falling sand grid core
// grid geometry, field widths, operation codes and engine control struct
// ============================================================================
package fsgs_pkg;

    // grid geometry
    localparam int GRID_WIDTH  = 640;
    localparam int GRID_HEIGHT = 480;

    // index widths derived from the geometry
    localparam int COL_W = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int ROW_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

    // fixed field widths of the stream beats
    localparam int ROW_FIELD_W = 9;
    localparam int COL_FIELD_W = 10;
    localparam int FUNC_W      = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SWEEP = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    // one grid row as stored in the row memory
    typedef logic [GRID_WIDTH-1:0] row_bits_t;

    // control from the sequencer to the column engine
    typedef struct packed {
        logic load_below;  // below row buffer takes memory read data
        logic load_cur;    // current row buffer takes read data, column restarts
        logic shift;       // current row becomes the below row
        logic step;        // apply the sand rule at the current column
    } eng_ctl_t;

endpackage

// ===== rtl/falling_sand_grid_step_core.sv =====
// ============================================================================
// falling_sand_grid_step_core - falling sand grid with cell access and sweep
// grid rows live in a row memory; a sequencer handles cell writes and reads
// and sweeps the sand rule over row pairs from the bottom up
// ============================================================================
//
//  channel   dir  beat fields (low bit first)                   handshake
//  s_axis    in   tdata: row[8:0] col[18:9] cell_in[19] pad     s_tvalid/s_tready
//                 tuser: func[1:0]
//  m_axis    out  tdata: cell_out[0] pad                        m_tvalid/m_tready
//                 tuser: op_done[1:0]
//
//  - one input beat at a time; every beat yields exactly one output beat
//  - cell write or read: row read, modify and reply states in turn;
//    off-grid cell or unused op: straight to the reply state
//  - sweep: reply once every row pair is done, the column engine
//    handling one column per cycle
//  - after reset a clearing pass writes GRID_HEIGHT rows, one per cycle,
//    and no input beat is taken until it ends
//  - a stalled output beat holds in its register; a new input beat can still
//    be taken, and its reply waits until the register frees up
//
module falling_sand_grid_step_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row[8:0], col[18:9], cell_in[19], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // cell_out[0], zero pad
    output logic [1:0]  m_tuser    // op_done[1:0]
);

    import fsgs_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_CELL_RD  = 4'd2;
    localparam logic [3:0] ST_CELL_WB  = 4'd3;
    localparam logic [3:0] ST_RESP     = 4'd4;
    localparam logic [3:0] ST_SW_START = 4'd5;
    localparam logic [3:0] ST_SW_LDBOT = 4'd6;
    localparam logic [3:0] ST_SW_LDCUR = 4'd7;
    localparam logic [3:0] ST_SW_COL   = 4'd8;
    localparam logic [3:0] ST_SW_NEXT  = 4'd9;
    localparam logic [3:0] ST_SW_FIN   = 4'd10;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_HEIGHT - 1);
    localparam logic [ROW_W-1:0] ROW_TOP2 = ROW_W'(GRID_HEIGHT - 2);

    // unpacked input beat
    logic [FUNC_W-1:0]      in_func;
    logic [ROW_FIELD_W-1:0] in_row;
    logic [COL_FIELD_W-1:0] in_col;
    logic                   in_cell;
    logic                   in_inside;
    logic                   accept;

    assign in_func   = s_tuser;
    assign in_row    = s_tdata[8:0];
    assign in_col    = s_tdata[18:9];
    assign in_cell   = s_tdata[19];
    assign in_inside = (int'(in_row) < GRID_HEIGHT) && (int'(in_col) < GRID_WIDTH);
    assign accept    = s_tvalid && s_tready;

    // sequencer registers
    logic [3:0]             state_reg, state_next;
    logic [ROW_W-1:0]       clr_reg, clr_next;
    logic [ROW_W-1:0]       y_reg, y_next;        // row of the current buffer in a sweep
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [ROW_FIELD_W-1:0] row_reg, row_next;
    logic [COL_FIELD_W-1:0] col_reg, col_next;
    logic                   cell_in_reg, cell_in_next;
    logic                   res_reg, res_next;

    // output beat register
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_cell_reg, m_cell_next;
    logic [FUNC_W-1:0] m_op_reg, m_op_next;
    logic              out_free;

    // row memory port
    logic             ram_wr_en, ram_rd_en;
    logic [ROW_W-1:0] ram_wr_addr, ram_rd_addr;
    row_bits_t        ram_wr_data, ram_rd_data;
    row_bits_t        cell_row_mod;

    // column engine
    eng_ctl_t  eng_ctl;
    row_bits_t eng_below, eng_cur;
    logic      eng_last;

    fsgs_row_ram #(
        .DEPTH (GRID_HEIGHT),
        .WIDTH (GRID_WIDTH)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fsgs_col_engine u_col_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (eng_ctl),
        .row_data  (ram_rd_data),
        .below_row (eng_below),
        .cur_row   (eng_cur),
        .last_col  (eng_last)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // row with the addressed cell replaced, for a cell write
    always_comb
    begin
        cell_row_mod = ram_rd_data;
        cell_row_mod[COL_W'(col_reg)] = cell_in_reg;
    end

    // memory port and engine control by state
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        eng_ctl     = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
            end
            ST_CELL_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ROW_W'(row_reg);
            end
            ST_CELL_WB:
            begin
                ram_wr_en   = (func_reg == FUNC_WRITE);
                ram_wr_addr = ROW_W'(row_reg);
                ram_wr_data = cell_row_mod;
            end
            ST_SW_START:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ROW_LAST;
            end
            ST_SW_LDBOT:
            begin
                eng_ctl.load_below = 1'b1;
                ram_rd_en          = 1'b1;
                ram_rd_addr        = y_reg;
            end
            ST_SW_LDCUR:
            begin
                eng_ctl.load_cur = 1'b1;
            end
            ST_SW_COL:
            begin
                eng_ctl.step = 1'b1;
            end
            ST_SW_NEXT:
            begin
                // finished lower row goes back, next row up comes in
                ram_wr_en     = 1'b1;
                ram_wr_addr   = y_reg + 1'b1;
                ram_wr_data   = eng_below;
                ram_rd_en     = (y_reg != '0);
                ram_rd_addr   = y_reg - 1'b1;
                eng_ctl.shift = (y_reg != '0);
            end
            ST_SW_FIN:
            begin
                // top row is the last one left in the engine
                ram_wr_en   = 1'b1;
                ram_wr_addr = y_reg;
                ram_wr_data = eng_cur;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        y_next        = y_reg;
        func_next     = func_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cell_in_next  = cell_in_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_cell_next   = m_cell_reg;
        m_op_next     = m_op_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ROW_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next    = in_func;
                    row_next     = in_row;
                    col_next     = in_col;
                    cell_in_next = in_cell;
                    res_next     = 1'b0;
                    priority if (in_func == FUNC_SWEEP)
                    begin
                        state_next = ST_SW_START;
                    end
                    else if (in_inside &&
                             (in_func == FUNC_WRITE || in_func == FUNC_READ))
                    begin
                        state_next = ST_CELL_RD;
                    end
                    else
                    begin
                        // unused operation or cell outside the grid
                        state_next = ST_RESP;
                    end
                end
            end
            ST_CELL_RD:
            begin
                state_next = ST_CELL_WB;
            end
            ST_CELL_WB:
            begin
                if (func_reg == FUNC_READ)
                begin
                    res_next = ram_rd_data[COL_W'(col_reg)];
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_cell_next   = res_reg;
                    m_op_next     = func_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_SW_START:
            begin
                y_next     = ROW_TOP2;
                state_next = ST_SW_LDBOT;
            end
            ST_SW_LDBOT:
            begin
                state_next = ST_SW_LDCUR;
            end
            ST_SW_LDCUR:
            begin
                state_next = ST_SW_COL;
            end
            ST_SW_COL:
            begin
                if (eng_last)
                begin
                    state_next = ST_SW_NEXT;
                end
            end
            ST_SW_NEXT:
            begin
                if (y_reg == '0)
                begin
                    state_next = ST_SW_FIN;
                end
                else
                begin
                    y_next     = y_reg - 1'b1;
                    state_next = ST_SW_LDCUR;
                end
            end
            ST_SW_FIN:
            begin
                state_next = ST_RESP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            y_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            y_reg        <= y_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // beat payload, no reset
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        cell_in_reg <= cell_in_next;
        res_reg     <= res_next;
        m_cell_reg  <= m_cell_next;
        m_op_reg    <= m_op_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_cell_reg};
    assign m_tuser  = m_op_reg;

`ifndef SYNTHESIS
    // only one item in flight: the beat after an accept is never taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input beat taken while an item is in flight");

    // a reply never overwrites a beat still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready && state_reg == ST_RESP) |=>
        (state_reg == ST_RESP))
        else $error("reply loaded over a stalled output beat");

    // sweep row pointer stays below the bottom row
    a_sweep_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SW_COL || state_reg == ST_SW_NEXT) |-> (y_reg <= ROW_TOP2))
        else $error("sweep row pointer out of range");

    // grid memory is never written with a cell value while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_wr_en)
        else $error("row memory written while idle");
`endif

endmodule

// ===== rtl/fsgs_row_ram.sv =====
// ============================================================================
// fsgs_row_ram - single clock row memory
// one write and one registered read per cycle
// ============================================================================
module fsgs_row_ram #(
    parameter int DEPTH = 480,
    parameter int WIDTH = 640
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/fsgs_col_engine.sv =====
// ============================================================================
// fsgs_col_engine - column engine for one row pair
// holds the current row and the row below, applies the sand rule one column
// per cycle from left to right
// ============================================================================
module fsgs_col_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  fsgs_pkg::eng_ctl_t  ctl,
    input  fsgs_pkg::row_bits_t row_data,
    output fsgs_pkg::row_bits_t below_row,
    output fsgs_pkg::row_bits_t cur_row,
    output logic                last_col
);

    import fsgs_pkg::*;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);

    row_bits_t        cur_reg, cur_next;
    row_bits_t        below_reg, below_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic [COL_W-1:0] idx_r, idx_l;
    logic             has_r, has_l;
    logic             grain, below_free, right_free, left_free;

    // neighbor indexes, clamped at the edges and masked by has_r / has_l
    assign has_r = (col_reg != COL_LAST);
    assign has_l = (col_reg != '0);
    assign idx_r = has_r ? col_reg + 1'b1 : col_reg;
    assign idx_l = has_l ? col_reg - 1'b1 : col_reg;

    assign grain      = cur_reg[col_reg];
    assign below_free = !below_reg[col_reg];
    assign right_free = has_r && !below_reg[idx_r];
    assign left_free  = has_l && !below_reg[idx_l];

    always_comb
    begin
        cur_next   = cur_reg;
        below_next = below_reg;
        col_next   = col_reg;
        if (ctl.load_cur)
        begin
            cur_next = row_data;
            col_next = '0;
        end
        if (ctl.load_below)
        begin
            below_next = row_data;
        end
        if (ctl.shift)
        begin
            below_next = cur_reg;
        end
        if (ctl.step)
        begin
            col_next = last_col ? '0 : col_reg + 1'b1;
            // straight down first, then down-right, then down-left
            priority if (grain && below_free)
            begin
                cur_next[col_reg]   = 1'b0;
                below_next[col_reg] = 1'b1;
            end
            else if (grain && right_free)
            begin
                cur_next[col_reg] = 1'b0;
                below_next[idx_r] = 1'b1;
            end
            else if (grain && left_free)
            begin
                cur_next[col_reg] = 1'b0;
                below_next[idx_l] = 1'b1;
            end
            else
            begin
                cur_next = cur_reg;
            end
        end
    end

    // row buffers are payload, no reset
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        below_reg <= below_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign below_row = below_reg;
    assign cur_row   = cur_reg;
    assign last_col  = (col_reg == COL_LAST);

`ifndef SYNTHESIS
    // a step moves grains but never creates or loses one
    a_grain_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |=> ($countones({cur_reg, below_reg}) ==
                      $past($countones({cur_reg, below_reg}))))
        else $error("grain count changed by a column step");

    // column index stays inside the row while stepping
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> (int'(col_reg) < GRID_WIDTH))
        else $error("column index out of range");

    // a grain over an empty cell must land straight below
    a_fall: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && cur_reg[col_reg] && !below_reg[col_reg])
        |=> below_reg[$past(col_reg)])
        else $error("grain did not fall into the empty cell below");
`endif

endmodule
